// ===== rtl/core/dakf_pkg.sv =====
// ============================================================================
// dakf_pkg: shared types and constants of the dual-axis angle Kalman filter
// Holds the command word between front end and core, the noise register
// set, register indexes and their reset values, and the sequencer states.
// ============================================================================
package dakf_pkg;

    // Fixed-point layout
    localparam int DAKF_FRAC    = 24;
    localparam int DAKF_NOISE_W = 24;
    localparam int DAKF_XW      = 70;   // wide working width for sums
    localparam int DAKF_MA_W    = 35;   // multiplier operand A
    localparam int DAKF_MB_W    = 33;   // multiplier operand B
    localparam int DAKF_PROD_W  = DAKF_MA_W + DAKF_MB_W;
    localparam int DAKF_RND_W   = DAKF_PROD_W - DAKF_FRAC;

    // Command queue depth
    localparam int DAKF_QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam int DAKF_CFG_IDX_W = 3;
    localparam logic [DAKF_CFG_IDX_W-1:0] REG_ROLL_ANGLE_NOISE    = 3'd0;
    localparam logic [DAKF_CFG_IDX_W-1:0] REG_ROLL_BIAS_NOISE     = 3'd1;
    localparam logic [DAKF_CFG_IDX_W-1:0] REG_ROLL_MEASURE_NOISE  = 3'd2;
    localparam logic [DAKF_CFG_IDX_W-1:0] REG_PITCH_ANGLE_NOISE   = 3'd3;
    localparam logic [DAKF_CFG_IDX_W-1:0] REG_PITCH_BIAS_NOISE    = 3'd4;
    localparam logic [DAKF_CFG_IDX_W-1:0] REG_PITCH_MEASURE_NOISE = 3'd5;

    // Register reset values
    localparam logic [DAKF_NOISE_W-1:0] RST_ROLL_ANGLE_NOISE    = 24'd167772;
    localparam logic [DAKF_NOISE_W-1:0] RST_ROLL_BIAS_NOISE     = 24'd503316;
    localparam logic [DAKF_NOISE_W-1:0] RST_ROLL_MEASURE_NOISE  = 24'd503316;
    localparam logic [DAKF_NOISE_W-1:0] RST_PITCH_ANGLE_NOISE   = 24'd16777;
    localparam logic [DAKF_NOISE_W-1:0] RST_PITCH_BIAS_NOISE    = 24'd50331;
    localparam logic [DAKF_NOISE_W-1:0] RST_PITCH_MEASURE_NOISE = 24'd503316;

    typedef enum logic {
        ACT_UPDATE = 1'b0,
        ACT_SET    = 1'b1
    } dakf_action_t;

    typedef struct packed {
        logic [DAKF_NOISE_W-1:0] angle_noise;
        logic [DAKF_NOISE_W-1:0] bias_noise;
        logic [DAKF_NOISE_W-1:0] measure_noise;
    } dakf_noise_t;

    typedef struct packed {
        dakf_action_t       action;
        logic               axis;
        logic signed [31:0] measured_angle;
        logic signed [31:0] gyro_rate;
        logic [23:0]        time_step;
    } dakf_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANG,
        ST_T,
        ST_P00,
        ST_P11,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_KY0,
        ST_KY1,
        ST_KA0,
        ST_KB0,
        ST_KA1,
        ST_KB1,
        ST_DONE
    } dakf_state_t;

endpackage

// ===== rtl/core/dakf_if.sv =====
// ============================================================================
// dakf_if: sample and result channels
// Valid/ready channels carrying one sample word in and one result word out.
// ============================================================================
interface dakf_sample_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic        axis;
    logic signed [31:0] measured_angle;
    logic signed [31:0] gyro_rate;
    logic [23:0] time_step;

    modport source (output valid, action, axis, measured_angle, gyro_rate, time_step,
                    input ready);
    modport sink   (input valid, action, axis, measured_angle, gyro_rate, time_step,
                    output ready);
endinterface

interface dakf_result_if;
    logic        valid;
    logic        ready;
    logic        axis_out;
    logic signed [31:0] filtered_angle;
    logic signed [31:0] unbiased_rate;

    modport source (output valid, axis_out, filtered_angle, unbiased_rate, input ready);
    modport sink   (input valid, axis_out, filtered_angle, unbiased_rate, output ready);
endinterface

// ===== rtl/core/dual_axis_angle_kalman_filter.sv =====
// ============================================================================
// dual_axis_angle_kalman_filter: roll and pitch angle/gyro-bias Kalman filter
// Top level: sample queue, filter core and noise configuration registers.
// ============================================================================
// Each sample word either updates the angle/bias filter of one axis or sets
// that axis' angle, and returns one result word with the axis, the filtered
// angle and the unbiased gyro rate (Q8.24, saturated). An update runs ten
// steps on the one shared 35x33 multiplier plus the gain divider, which
// delivers both gains in one pass. A two-entry queue in front of the core
// takes new samples while the core works, and the result register lets the
// core start the next item while a result waits. Noise registers must be
// written through the plain write port only while the block is idle; the
// block does not enforce this. Indexes past the list are ignored.
module dual_axis_angle_kalman_filter
    import dakf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DAKF_QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    dakf_sample_if.sink                sample,
    dakf_result_if.source              result,
    input  logic                       cfg_we,
    input  logic [DAKF_CFG_IDX_W-1:0]  cfg_index,
    input  logic [DAKF_NOISE_W-1:0]    cfg_wdata
);

    dakf_noise_t [1:0] noise_reg;
    logic              cmd_valid;
    logic              cmd_pop;
    dakf_cmd_t         cmd;

    // Noise configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg[0].angle_noise   <= RST_ROLL_ANGLE_NOISE;
            noise_reg[0].bias_noise    <= RST_ROLL_BIAS_NOISE;
            noise_reg[0].measure_noise <= RST_ROLL_MEASURE_NOISE;
            noise_reg[1].angle_noise   <= RST_PITCH_ANGLE_NOISE;
            noise_reg[1].bias_noise    <= RST_PITCH_BIAS_NOISE;
            noise_reg[1].measure_noise <= RST_PITCH_MEASURE_NOISE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROLL_ANGLE_NOISE:    noise_reg[0].angle_noise   <= cfg_wdata;
                REG_ROLL_BIAS_NOISE:     noise_reg[0].bias_noise    <= cfg_wdata;
                REG_ROLL_MEASURE_NOISE:  noise_reg[0].measure_noise <= cfg_wdata;
                REG_PITCH_ANGLE_NOISE:   noise_reg[1].angle_noise   <= cfg_wdata;
                REG_PITCH_BIAS_NOISE:    noise_reg[1].bias_noise    <= cfg_wdata;
                REG_PITCH_MEASURE_NOISE: noise_reg[1].measure_noise <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Front end: intake and command queue.
    dakf_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back end: filter sequencer.
    dakf_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .noise     (noise_reg),
        .result    (result)
    );

    // The core only takes a command that the queue holds.
    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // An accepted sample is visible to the core on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (sample.valid && sample.ready) |=> cmd_valid)
        else $error("accepted sample missing from queue");

    // A roll measurement noise write lands in its register.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (cfg_we && cfg_index == REG_ROLL_MEASURE_NOISE)
                     |=> noise_reg[0].measure_noise == $past(cfg_wdata))
        else $error("roll measurement noise write lost");

endmodule

// ===== rtl/core/dakf_front.sv =====
// ============================================================================
// dakf_front: sample intake and command queue
// Accepts sample words, classifies them as update or set commands and
// holds them in a short queue for the core.
// ============================================================================
module dakf_front
    import dakf_pkg::*;
#(
    parameter int QUEUE_DEPTH = DAKF_QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    dakf_sample_if.sink      sample,
    output logic             cmd_valid,
    output dakf_cmd_t        cmd,
    input  logic             cmd_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    dakf_cmd_t         queue_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              push;
    dakf_cmd_t         new_cmd;

    // Classify the incoming word.
    always_comb
    begin
        new_cmd.action         = sample.action ? ACT_SET : ACT_UPDATE;
        new_cmd.axis           = sample.axis;
        new_cmd.measured_angle = sample.measured_angle;
        new_cmd.gyro_rate      = sample.gyro_rate;
        new_cmd.time_step      = sample.time_step;
    end

    assign sample.ready = (count_reg != CW'(QUEUE_DEPTH));
    assign push         = sample.valid && sample.ready;
    assign cmd_valid    = (count_reg != '0);
    assign cmd          = queue_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !cmd_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && cmd_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/dakf_div.sv =====
// ============================================================================
// dakf_div: two-lane radix-2 gain divider
// Computes sat(num * 2^24 / den) truncated toward zero for two numerators
// that share one denominator, one quotient bit per cycle.
// ============================================================================
module dakf_div
    import dakf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num0,
    input  logic signed [31:0] num1,
    input  logic signed [33:0] den,
    output logic               done,
    output logic signed [31:0] quot0,
    output logic signed [31:0] quot1
);

    localparam int QB = 31;                 // quotient bits below saturation
    localparam int NW = 32 + DAKF_FRAC;     // scaled numerator width
    localparam int DW = 33;                 // divisor magnitude width
    localparam int SW = DW + QB - 1;        // shifted divisor width

    logic [NW-1:0]  rem_reg [2];
    logic [QB-1:0]  q_reg [2];
    logic           ovf_reg [2];
    logic           neg_reg [2];
    logic [SW-1:0]  ds_reg;
    logic [4:0]     cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [DW-1:0]  den_mag;
    logic [31:0]    num_mag [2];
    logic signed [31:0] num_in [2];
    logic signed [31:0] quot [2];

    assign num_in[0] = num0;
    assign num_in[1] = num1;
    assign den_mag   = den[33] ? DW'(-den) : DW'(den);

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            num_mag[i] = num_in[i][31] ? 32'(-num_in[i]) : 32'(num_in[i]);
        end
    end

    // Sign and saturation of each quotient.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (ovf_reg[i])
            begin
                quot[i] = neg_reg[i] ? 32'sh80000000 : 32'sh7fffffff;
            end
            else
            begin
                quot[i] = neg_reg[i] ? -$signed({1'b0, q_reg[i]}) : $signed({1'b0, q_reg[i]});
            end
        end
    end

    assign quot0 = quot[0];
    assign quot1 = quot[1];
    assign done  = done_reg;

    // Lane datapath: restoring division step.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ds_reg <= SW'({den_mag, {(QB - 1){1'b0}}});
            for (int i = 0; i < 2; i++)
            begin
                rem_reg[i] <= {num_mag[i], {DAKF_FRAC{1'b0}}};
                q_reg[i]   <= '0;
                neg_reg[i] <= num_in[i][31] ^ den[33];
                ovf_reg[i] <= (64'({num_mag[i], {DAKF_FRAC{1'b0}}}) >=
                               64'({den_mag, {QB{1'b0}}}));
            end
        end
        else if (busy_reg)
        begin
            ds_reg <= ds_reg >> 1;
            for (int i = 0; i < 2; i++)
            begin
                if (SW'(rem_reg[i]) >= ds_reg)
                begin
                    rem_reg[i] <= rem_reg[i] - ds_reg[NW-1:0];
                    q_reg[i]   <= {q_reg[i][QB-2:0], 1'b1};
                end
                else
                begin
                    q_reg[i] <= {q_reg[i][QB-2:0], 1'b0};
                end
            end
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(QB - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/dakf_core.sv =====
// ============================================================================
// dakf_core: filter sequencer
// Runs one command at a time: an update does predict, covariance propagation,
// gain division and correction with one shared multiplier, a set skips them;
// then both write back the axis state and register the result word.
// ============================================================================
module dakf_core
    import dakf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  dakf_cmd_t          cmd,
    output logic               cmd_pop,
    input  dakf_noise_t [1:0]  noise,
    dakf_result_if.source      result
);

    dakf_state_t state_reg;
    dakf_state_t state_next;
    logic        phase_reg;
    logic        phase_next;

    // Per-axis filter state
    logic signed [31:0] ang_st [2];
    logic signed [31:0] bias_st [2];
    logic signed [31:0] rate_st [2];
    logic signed [31:0] cov_st [2][4];

    // Working registers for the command in flight
    logic               axis_reg;
    logic signed [31:0] meas_reg;
    logic [23:0]        dt_reg;
    logic signed [31:0] ang_w, bias_w, rate_w;
    logic signed [31:0] p00_w, p01_w, p10_w, p11_w;
    logic signed [31:0] t_reg, y_reg, a_reg, b_reg, k0_reg, k1_reg;
    logic signed [DAKF_PROD_W-1:0] prod_reg;

    // Output word register
    logic               out_valid_reg;
    logic               out_axis_reg;
    logic signed [31:0] out_angle_reg;
    logic signed [31:0] out_rate_reg;

    logic signed [DAKF_MA_W-1:0] mul_a;
    logic signed [DAKF_MB_W-1:0] mul_b;
    logic signed [DAKF_RND_W-1:0] rp;
    logic signed [33:0] s_val;
    logic               div_start, div_done;
    logic signed [31:0] q0, q1;
    logic               out_load;
    logic               is_mul;
    dakf_noise_t        cur_noise;

    function automatic logic signed [DAKF_RND_W-1:0] rnd24(
        input logic signed [DAKF_PROD_W-1:0] p);
        logic signed [DAKF_PROD_W-1:0] w;
        w = p + DAKF_PROD_W'(1 << (DAKF_FRAC - 1));
        return w[DAKF_PROD_W-1:DAKF_FRAC];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [DAKF_XW-1:0] v);
        if (v > DAKF_XW'(64'sd2147483647))
        begin
            return 32'sh7fffffff;
        end
        else if (v < DAKF_XW'(-64'sd2147483648))
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    assign cur_noise = noise[axis_reg];
    assign rp        = rnd24(prod_reg);
    assign s_val     = 34'(p00_w) + $signed({10'b0, cur_noise.measure_noise});

    // Shared gain divider.
    dakf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num0  (p00_w),
        .num1  (p10_w),
        .den   (s_val),
        .done  (div_done),
        .quot0 (q0),
        .quot1 (q1)
    );

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ANG:
            begin
                mul_a = DAKF_MA_W'(rate_w);
                mul_b = $signed({9'b0, dt_reg});
            end
            ST_T:
            begin
                mul_a = DAKF_MA_W'(p11_w);
                mul_b = $signed({9'b0, dt_reg});
            end
            ST_P00:
            begin
                mul_a = DAKF_MA_W'(t_reg) - DAKF_MA_W'(p01_w) - DAKF_MA_W'(p10_w)
                        + $signed({11'b0, cur_noise.angle_noise});
                mul_b = $signed({9'b0, dt_reg});
            end
            ST_P11:
            begin
                mul_a = $signed({11'b0, cur_noise.bias_noise});
                mul_b = $signed({9'b0, dt_reg});
            end
            ST_KY0:
            begin
                mul_a = DAKF_MA_W'(y_reg);
                mul_b = DAKF_MB_W'(k0_reg);
            end
            ST_KY1:
            begin
                mul_a = DAKF_MA_W'(y_reg);
                mul_b = DAKF_MB_W'(k1_reg);
            end
            ST_KA0:
            begin
                mul_a = DAKF_MA_W'(a_reg);
                mul_b = DAKF_MB_W'(k0_reg);
            end
            ST_KB0:
            begin
                mul_a = DAKF_MA_W'(b_reg);
                mul_b = DAKF_MB_W'(k0_reg);
            end
            ST_KA1:
            begin
                mul_a = DAKF_MA_W'(a_reg);
                mul_b = DAKF_MB_W'(k1_reg);
            end
            ST_KB1:
            begin
                mul_a = DAKF_MA_W'(b_reg);
                mul_b = DAKF_MB_W'(k1_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Each multiply state has a product phase, then a use phase.
    always_comb
    begin
        case (state_reg)
            ST_ANG, ST_T, ST_P00, ST_P11,
            ST_KY0, ST_KY1, ST_KA0, ST_KB0, ST_KA1, ST_KB1: is_mul = 1'b1;
            default:                                         is_mul = 1'b0;
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        phase_next = is_mul ? ~phase_reg : 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd.action == ACT_SET) ? ST_DONE : ST_ANG;
                end
            end
            ST_ANG:       state_next = phase_reg ? ST_T   : ST_ANG;
            ST_T:         state_next = phase_reg ? ST_P00 : ST_T;
            ST_P00:       state_next = phase_reg ? ST_P11 : ST_P00;
            ST_P11:       state_next = phase_reg ? ST_DIV_START : ST_P11;
            ST_DIV_START: state_next = (s_val == '0) ? ST_KY0 : ST_DIV_WAIT;
            ST_DIV_WAIT:  state_next = div_done ? ST_KY0 : ST_DIV_WAIT;
            ST_KY0:       state_next = phase_reg ? ST_KY1 : ST_KY0;
            ST_KY1:       state_next = phase_reg ? ST_KA0 : ST_KY1;
            ST_KA0:       state_next = phase_reg ? ST_KB0 : ST_KA0;
            ST_KB0:       state_next = phase_reg ? ST_KA1 : ST_KB0;
            ST_KA1:       state_next = phase_reg ? ST_KB1 : ST_KA1;
            ST_KB1:       state_next = phase_reg ? ST_DONE : ST_KB1;
            ST_DONE:      state_next = out_load ? ST_IDLE : ST_DONE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;
        div_start = (state_reg == ST_DIV_START) && (s_val != '0);
        out_load  = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    end

    // Working datapath.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    axis_reg <= cmd.axis;
                    meas_reg <= cmd.measured_angle;
                    dt_reg   <= cmd.time_step;
                    bias_w   <= bias_st[cmd.axis];
                    p00_w    <= cov_st[cmd.axis][0];
                    p01_w    <= cov_st[cmd.axis][1];
                    p10_w    <= cov_st[cmd.axis][2];
                    p11_w    <= cov_st[cmd.axis][3];
                    if (cmd.action == ACT_SET)
                    begin
                        ang_w  <= cmd.measured_angle;
                        rate_w <= rate_st[cmd.axis];
                    end
                    else
                    begin
                        ang_w  <= ang_st[cmd.axis];
                        rate_w <= sat32(DAKF_XW'($signed(cmd.gyro_rate))
                                        - DAKF_XW'(bias_st[cmd.axis]));
                    end
                end
            end
            ST_ANG:
            begin
                if (phase_reg)
                begin
                    ang_w <= sat32(DAKF_XW'(ang_w) + DAKF_XW'(rp));
                end
            end
            ST_T:
            begin
                if (phase_reg)
                begin
                    t_reg <= rp[31:0];
                end
            end
            ST_P00:
            begin
                if (phase_reg)
                begin
                    p00_w <= sat32(DAKF_XW'(p00_w) + DAKF_XW'(rp));
                    p01_w <= sat32(DAKF_XW'(p01_w) - DAKF_XW'(t_reg));
                    p10_w <= sat32(DAKF_XW'(p10_w) - DAKF_XW'(t_reg));
                end
            end
            ST_P11:
            begin
                if (phase_reg)
                begin
                    p11_w <= sat32(DAKF_XW'(p11_w) + DAKF_XW'(rp));
                end
            end
            ST_DIV_START:
            begin
                y_reg  <= sat32(DAKF_XW'(meas_reg) - DAKF_XW'(ang_w));
                a_reg  <= p00_w;
                b_reg  <= p01_w;
                k0_reg <= '0;
                k1_reg <= '0;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    k0_reg <= q0;
                    k1_reg <= q1;
                end
            end
            ST_KY0:
            begin
                if (phase_reg)
                begin
                    ang_w <= sat32(DAKF_XW'(ang_w) + DAKF_XW'(rp));
                end
            end
            ST_KY1:
            begin
                if (phase_reg)
                begin
                    bias_w <= sat32(DAKF_XW'(bias_w) + DAKF_XW'(rp));
                end
            end
            ST_KA0:
            begin
                if (phase_reg)
                begin
                    p00_w <= sat32(DAKF_XW'(a_reg) - DAKF_XW'(rp));
                end
            end
            ST_KB0:
            begin
                if (phase_reg)
                begin
                    p01_w <= sat32(DAKF_XW'(b_reg) - DAKF_XW'(rp));
                end
            end
            ST_KA1:
            begin
                if (phase_reg)
                begin
                    p10_w <= sat32(DAKF_XW'(p10_w) - DAKF_XW'(rp));
                end
            end
            ST_KB1:
            begin
                if (phase_reg)
                begin
                    p11_w <= sat32(DAKF_XW'(p11_w) - DAKF_XW'(rp));
                end
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_axis_reg  <= axis_reg;
            out_angle_reg <= ang_w;
            out_rate_reg  <= rate_w;
        end
    end

    // Control state, axis state write-back and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                ang_st[i]  <= '0;
                bias_st[i] <= '0;
                rate_st[i] <= '0;
                for (int j = 0; j < 4; j++)
                begin
                    cov_st[i][j] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                ang_st[axis_reg]     <= ang_w;
                bias_st[axis_reg]    <= bias_w;
                rate_st[axis_reg]    <= rate_w;
                cov_st[axis_reg][0]  <= p00_w;
                cov_st[axis_reg][1]  <= p01_w;
                cov_st[axis_reg][2]  <= p10_w;
                cov_st[axis_reg][3]  <= p11_w;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.axis_out       = out_axis_reg;
    assign result.filtered_angle = out_angle_reg;
    assign result.unbiased_rate  = out_rate_reg;

endmodule
